// ----- hdl/ztf_pkg.sv -----
// Shared types, register map and status codes for the per-target z-score range filter.
package ztf_pkg;

  localparam int unsigned ID_W     = 8;
  localparam int unsigned DIST_W   = 18;
  localparam int unsigned STAMP_W  = 48;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned FILL_W   = 4;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 32;

  // register indexes
  localparam logic [2:0] REG_NUM_TARGETS  = 3'd0;
  localparam logic [2:0] REG_OWN_ID       = 3'd1;
  localparam logic [2:0] REG_WINDOW_LEN   = 3'd2;
  localparam logic [2:0] REG_Z_LIMIT      = 3'd3;
  localparam logic [2:0] REG_MIN_SIGMA    = 3'd4;
  localparam logic [2:0] REG_MIN_RANGE    = 3'd5;
  localparam logic [2:0] REG_REJECT_LIMIT = 3'd6;
  localparam logic [2:0] REG_WARMUP_SIGMA = 3'd7;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_ACCEPT      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_WARMUP      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REJ_RESTART = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OUTLIER     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_INVALID     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE   = 3'd5;

  typedef struct packed {
    logic [4:0]  num_targets;
    logic [7:0]  own_id;
    logic [3:0]  window_length;
    logic [7:0]  z_limit_q4_4;
    logic [11:0] min_sigma_mm;
    logic [17:0] min_range_mm;
    logic [7:0]  reject_limit;
    logic [11:0] warmup_sigma_mm;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    num_targets:     5'd4,
    own_id:          8'd0,
    window_length:   4'd5,
    z_limit_q4_4:    8'd48,
    min_sigma_mm:    12'd80,
    min_range_mm:    18'd100,
    reject_limit:    8'd5,
    warmup_sigma_mm: 12'd20
  };

  typedef struct packed {
    logic               frame_start;
    logic               invalid;
    logic [ID_W-1:0]    partner_id;
    logic [DIST_W-1:0]  distance;
    logic [STAMP_W-1:0] stamp;
  } item_t;

endpackage

// ----- hdl/per_target_zscore_range_filter.sv -----
// Top level of the per-target z-score range filter: register port, front, queue and window engine.
// One range sample is handled at a time by the window engine while the front and a two-entry
// queue keep taking samples until the queue is full. An invalid or duplicate sample is popped,
// classified and sent straight to output. A valid sample walks its target's window through the
// single read port of the window memory. When the window is full or first fills (n entries), a
// first walk feeds the statistics and decision; an outlier then goes straight to output, any other
// sample gets a second walk. The last walk of a kept sample feeds the mean division and output.
// Results wait in an output register, so a stall downstream only holds the engine once the next
// result is ready.
module per_target_zscore_range_filter import ztf_pkg::*; #(
  parameter int unsigned MAX_TARGETS = 16,
  parameter int unsigned WINDOW_MAX  = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                frame_start_i,
  input  logic [ID_W-1:0]     partner_id_i,
  input  logic [DIST_W-1:0]   distance_mm_i,
  input  logic                distance_finite_i,
  input  logic [STAMP_W-1:0]  stamp_us_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                accepted_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [ID_W-1:0]     out_target_o,
  output logic [DIST_W-1:0]   filtered_mm_o,
  output logic [STAMP_W-1:0]  effective_stamp_us_o,
  output logic [FILL_W-1:0]   fill_count_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  cfg_t  cfg_q, cfg_d;
  logic  q_full, q_push, q_valid, q_pop;
  item_t front_item, q_item;
  logic  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (paddr[ADDR_W-1:2])
        REG_NUM_TARGETS:  cfg_d.num_targets     = pwdata[4:0];
        REG_OWN_ID:       cfg_d.own_id          = pwdata[7:0];
        REG_WINDOW_LEN:   cfg_d.window_length   = pwdata[3:0];
        REG_Z_LIMIT:      cfg_d.z_limit_q4_4    = pwdata[7:0];
        REG_MIN_SIGMA:    cfg_d.min_sigma_mm    = pwdata[11:0];
        REG_MIN_RANGE:    cfg_d.min_range_mm    = pwdata[17:0];
        REG_REJECT_LIMIT: cfg_d.reject_limit    = pwdata[7:0];
        REG_WARMUP_SIGMA: cfg_d.warmup_sigma_mm = pwdata[11:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[ADDR_W-1:2])
      REG_NUM_TARGETS:  prdata = DATA_W'(cfg_q.num_targets);
      REG_OWN_ID:       prdata = DATA_W'(cfg_q.own_id);
      REG_WINDOW_LEN:   prdata = DATA_W'(cfg_q.window_length);
      REG_Z_LIMIT:      prdata = DATA_W'(cfg_q.z_limit_q4_4);
      REG_MIN_SIGMA:    prdata = DATA_W'(cfg_q.min_sigma_mm);
      REG_MIN_RANGE:    prdata = DATA_W'(cfg_q.min_range_mm);
      REG_REJECT_LIMIT: prdata = DATA_W'(cfg_q.reject_limit);
      REG_WARMUP_SIGMA: prdata = DATA_W'(cfg_q.warmup_sigma_mm);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ztf_front #(.MAX_TARGETS(MAX_TARGETS)) u_front (
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .frame_start_i     (frame_start_i),
    .partner_id_i      (partner_id_i),
    .distance_mm_i     (distance_mm_i),
    .distance_finite_i (distance_finite_i),
    .stamp_us_i        (stamp_us_i),
    .cfg_i             (cfg_q),
    .q_full_i          (q_full),
    .push_o            (q_push),
    .item_o            (front_item)
  );

  ztf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (front_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .item_o  (q_item)
  );

  ztf_back #(.MAX_TARGETS(MAX_TARGETS), .WINDOW_MAX(WINDOW_MAX)) u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_i                (cfg_q),
    .q_valid_i            (q_valid),
    .q_item_i             (q_item),
    .q_pop_o              (q_pop),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .accepted_o           (accepted_o),
    .status_o             (status_o),
    .out_target_o         (out_target_o),
    .filtered_mm_o        (filtered_mm_o),
    .effective_stamp_us_o (effective_stamp_us_o),
    .fill_count_o         (fill_count_o)
  );

`ifndef NO_ASSERTIONS
  a_accept_matches_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (accepted_o == (status_o == ST_ACCEPT || status_o == ST_WARMUP ||
                                    status_o == ST_REJ_RESTART)))
    else $error("accepted flag disagrees with status");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !accepted_o) |->
      (fill_count_o == '0 && filtered_mm_o == '0 && effective_stamp_us_o == '0))
    else $error("rejected item carries window data");

  a_accept_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && accepted_o) |-> (fill_count_o != '0))
    else $error("accepted item with empty window");

  a_restart_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_WARMUP || status_o == ST_REJ_RESTART)) |->
      (fill_count_o == FILL_W'(1)))
    else $error("restarted window does not hold exactly one item");
`endif

endmodule

// ----- hdl/ztf_front.sv -----
// Input side: screens each sample against the configuration and hands it to the queue.
module ztf_front import ztf_pkg::*; #(
  parameter int unsigned MAX_TARGETS = 16
) (
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               frame_start_i,
  input  logic [ID_W-1:0]    partner_id_i,
  input  logic [DIST_W-1:0]  distance_mm_i,
  input  logic               distance_finite_i,
  input  logic [STAMP_W-1:0] stamp_us_i,
  input  cfg_t               cfg_i,
  input  logic               q_full_i,
  output logic               push_o,
  output item_t              item_o
);

  logic [4:0] nt_eff;
  logic       id_bad;

  always_comb begin
    nt_eff = (cfg_i.num_targets == 5'd0) ? 5'd1 : cfg_i.num_targets;
    id_bad = (partner_id_i >= {3'b000, nt_eff}) ||
             ({1'b0, partner_id_i} >= (ID_W + 1)'(MAX_TARGETS)) ||
             (partner_id_i == cfg_i.own_id);
  end

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    item_o.frame_start = frame_start_i;
    item_o.invalid     = id_bad || !distance_finite_i || (distance_mm_i < cfg_i.min_range_mm);
    item_o.partner_id  = partner_id_i;
    item_o.distance    = distance_mm_i;
    item_o.stamp       = stamp_us_i;
  end

endmodule

// ----- hdl/ztf_queue.sv -----
// Two-entry queue between the screening front and the window engine.
module ztf_queue import ztf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  output logic  valid_o,
  input  logic  pop_i,
  output item_t item_o
);

  localparam int unsigned DEPTH = 2;

  item_t      mem_q [DEPTH];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'(DEPTH));
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ----- hdl/ztf_div.sv -----
// Iterative restoring divider by a small divisor, three quotient bits per cycle.
module ztf_div #(
  parameter int unsigned DW = 52,
  parameter int unsigned NW = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] divisor_i,
  input  logic [DW-1:0] dividend_i,
  output logic          busy_o,
  output logic [DW-1:0] quot_o
);

  localparam int unsigned BPC   = 3;
  localparam int unsigned STEPS = (DW + BPC - 1) / BPC;
  localparam int unsigned PW    = STEPS * BPC;
  localparam int unsigned CW    = $clog2(STEPS + 1);

  logic [PW-1:0] dq_q, dq_d;
  logic [NW-1:0] rem_q, rem_d;
  logic [NW-1:0] div_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;

  always_comb begin
    logic [NW:0] rem_t;
    dq_d   = dq_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    rem_t  = '0;
    if (start_i) begin
      dq_d   = PW'(dividend_i);
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      for (int i = 0; i < BPC; i++) begin
        rem_t = {rem_d, dq_d[PW-1]};
        dq_d  = {dq_d[PW-2:0], 1'b0};
        if (rem_t >= {1'b0, div_q}) begin
          rem_d    = NW'(rem_t - {1'b0, div_q});
          dq_d[0]  = 1'b1;
        end else begin
          rem_d = rem_t[NW-1:0];
        end
      end
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(STEPS - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    if (start_i) begin
      div_q <= divisor_i;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = dq_q[DW-1:0];

endmodule

// ----- hdl/ztf_back.sv -----
// Window engine: per-target window memories, statistics, z test, restarts and the result register.
module ztf_back import ztf_pkg::*; #(
  parameter int unsigned MAX_TARGETS = 16,
  parameter int unsigned WINDOW_MAX  = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                q_valid_i,
  input  item_t               q_item_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                accepted_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [ID_W-1:0]     out_target_o,
  output logic [DIST_W-1:0]   filtered_mm_o,
  output logic [STAMP_W-1:0]  effective_stamp_us_o,
  output logic [FILL_W-1:0]   fill_count_o
);

  localparam int unsigned TW    = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int unsigned WW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned FW    = $clog2(WINDOW_MAX + 1);
  localparam int unsigned PSW   = FW + 1;
  localparam int unsigned DEPTH = MAX_TARGETS * WINDOW_MAX;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SW    = DIST_W + FW;
  localparam int unsigned QW    = 2 * DIST_W + FW;
  localparam int unsigned TSW   = STAMP_W + FW;
  localparam int unsigned VW    = QW + FW;
  localparam int unsigned NNW   = 2 * FW;
  localparam int unsigned SQ12W = 24;
  localparam int unsigned THW   = NNW + SQ12W;
  localparam int unsigned LW    = 2 * SW + 8;
  localparam int unsigned RW    = 16 + VW;
  localparam int unsigned CMPW  = (LW > RW) ? LW : RW;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLASS  = 4'd1;
  localparam logic [3:0] S_SUM    = 4'd2;
  localparam logic [3:0] S_STAT1  = 4'd3;
  localparam logic [3:0] S_STAT2  = 4'd4;
  localparam logic [3:0] S_STAT3  = 4'd5;
  localparam logic [3:0] S_STAT4  = 4'd6;
  localparam logic [3:0] S_DECIDE = 4'd7;
  localparam logic [3:0] S_DIV    = 4'd8;
  localparam logic [3:0] S_DIVW   = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  localparam logic [1:0] M_WARM  = 2'd0;
  localparam logic [1:0] M_ZTEST = 2'd1;
  localparam logic [1:0] M_FINAL = 2'd2;

  function automatic logic [WW-1:0] wrap_pos(input logic [PSW-1:0] x);
    if (x >= PSW'(WINDOW_MAX)) begin
      return WW'(x - PSW'(WINDOW_MAX));
    end
    return WW'(x);
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [TW-1:0] t, input logic [WW-1:0] p);
    return AW'(t) * AW'(WINDOW_MAX) + AW'(p);
  endfunction

  // per-target control state
  logic [FW-1:0]          fill_q  [MAX_TARGETS];
  logic [WW-1:0]          head_q  [MAX_TARGETS];
  logic [7:0]             rrun_q  [MAX_TARGETS];
  logic [MAX_TARGETS-1:0] warm_q;
  logic [MAX_TARGETS-1:0] seen_q;

  // window memories
  logic [DIST_W-1:0]  dist_mem  [DEPTH];
  logic [STAMP_W-1:0] stamp_mem [DEPTH];
  logic [DIST_W-1:0]  rd_dist_q;
  logic [STAMP_W-1:0] rd_stamp_q;

  logic [3:0]          state_q, state_d;
  logic [1:0]          mode_q, mode_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic                acc_q, acc_d;
  logic [FW-1:0]       k_q, k_d;
  logic                v1_q, v2_q;
  item_t               item_q;
  logic [TW-1:0]       tgt_q;

  logic [SW-1:0]          s_q;
  logic [QW-1:0]          q_q;
  logic [TSW-1:0]         ts_q;
  logic [2*DIST_W-1:0]    sq_q;

  logic [VW-1:0]    nq_q, ss_q, var_q, varm_q;
  logic [NNW-1:0]   nn_q;
  logic [SQ12W-1:0] w2_q, ms2_q;
  logic [15:0]      z2_q;
  logic [SW-1:0]    nd_q, diff_q;
  logic [THW-1:0]   thr_q, flo_q;
  logic [2*SW-1:0]  lhs_q;
  logic [RW-1:0]    rhs_q;

  logic [FW-1:0] fill_cur, len_eff, fill_wd;
  logic [WW-1:0] head_cur, head_wd;
  logic [7:0]    rr_cur, rr_inc, rr_wd;
  logic          fill_we, head_we, rr_we, warm_we, warm_wd, seen_set;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic          issue, sum_done, sum_clr;
  logic          pass, warm_restart;
  logic          div_start, div_busy_s, div_busy_t, out_load;
  logic [TSW-1:0] quot_s, quot_t;

  logic                out_valid_q;
  logic                out_acc_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [ID_W-1:0]     out_target_q;
  logic [DIST_W-1:0]   out_mm_q;
  logic [STAMP_W-1:0]  out_stamp_q;
  logic [FILL_W-1:0]   out_fill_q;

  assign fill_cur = fill_q[tgt_q];
  assign head_cur = head_q[tgt_q];
  assign rr_cur   = rrun_q[tgt_q];
  assign rr_inc   = (rr_cur == 8'hFF) ? rr_cur : rr_cur + 8'd1;

  always_comb begin
    if (cfg_i.window_length == 4'd0) begin
      len_eff = FW'(1);
    end else if ({2'b00, cfg_i.window_length} > 6'(WINDOW_MAX)) begin
      len_eff = FW'(WINDOW_MAX);
    end else begin
      len_eff = FW'(cfg_i.window_length);
    end
  end

  assign issue     = (state_q == S_SUM) && (k_q < fill_cur);
  assign sum_done  = (state_q == S_SUM) && !(k_q < fill_cur) && !v1_q && !v2_q;
  assign mem_raddr = addr_of(tgt_q, wrap_pos(PSW'(head_cur) + PSW'(k_q)));

  assign pass         = CMPW'({lhs_q, 8'h00}) <= CMPW'(rhs_q);
  assign warm_restart = VW'(thr_q) > var_q;

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    status_d  = status_q;
    acc_d     = acc_q;
    k_d       = k_q;
    sum_clr   = 1'b0;
    q_pop_o   = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = addr_of(tgt_q, '0);
    fill_we   = 1'b0;
    fill_wd   = fill_cur;
    head_we   = 1'b0;
    head_wd   = head_cur;
    rr_we     = 1'b0;
    rr_wd     = rr_cur;
    warm_we   = 1'b0;
    warm_wd   = 1'b0;
    seen_set  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          state_d = S_CLASS;
        end
      end
      S_CLASS: begin
        if (item_q.invalid) begin
          status_d = ST_INVALID;
          acc_d    = 1'b0;
          state_d  = S_OUT;
        end else if (seen_q[tgt_q]) begin
          status_d = ST_DUPLICATE;
          acc_d    = 1'b0;
          state_d  = S_OUT;
        end else if (fill_cur < len_eff) begin
          // still filling: push at the tail
          mem_we    = 1'b1;
          mem_waddr = addr_of(tgt_q, wrap_pos(PSW'(head_cur) + PSW'(fill_cur)));
          fill_we   = 1'b1;
          fill_wd   = fill_cur + FW'(1);
          rr_we     = 1'b1;
          rr_wd     = 8'd0;
          seen_set  = 1'b1;
          status_d  = ST_ACCEPT;
          acc_d     = 1'b1;
          mode_d    = ((fill_cur + FW'(1)) == len_eff && !warm_q[tgt_q]) ? M_WARM : M_FINAL;
          sum_clr   = 1'b1;
          state_d   = S_SUM;
        end else begin
          mode_d  = M_ZTEST;
          sum_clr = 1'b1;
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        if (issue) begin
          k_d = k_q + FW'(1);
        end
        if (sum_done) begin
          state_d = (mode_q == M_FINAL) ? S_DIV : S_STAT1;
        end
      end
      S_STAT1: state_d = S_STAT2;
      S_STAT2: state_d = S_STAT3;
      S_STAT3: state_d = S_STAT4;
      S_STAT4: state_d = S_DECIDE;
      S_DECIDE: begin
        sum_clr = 1'b1;
        state_d = S_SUM;
        mode_d  = M_FINAL;
        if (mode_q == M_WARM) begin
          if (warm_restart) begin
            mem_we    = 1'b1;
            mem_waddr = addr_of(tgt_q, '0);
            head_we   = 1'b1;
            head_wd   = '0;
            fill_we   = 1'b1;
            fill_wd   = FW'(1);
            warm_we   = 1'b1;
            warm_wd   = 1'b0;
            status_d  = ST_WARMUP;
          end else begin
            warm_we = 1'b1;
            warm_wd = 1'b1;
          end
        end else if (pass) begin
          // replace the oldest entry
          mem_we    = 1'b1;
          mem_waddr = addr_of(tgt_q, head_cur);
          head_we   = 1'b1;
          head_wd   = wrap_pos(PSW'(head_cur) + PSW'(1));
          rr_we     = 1'b1;
          rr_wd     = 8'd0;
          seen_set  = 1'b1;
          status_d  = ST_ACCEPT;
          acc_d     = 1'b1;
        end else if (rr_inc >= cfg_i.reject_limit) begin
          mem_we    = 1'b1;
          mem_waddr = addr_of(tgt_q, '0);
          head_we   = 1'b1;
          head_wd   = '0;
          fill_we   = 1'b1;
          fill_wd   = FW'(1);
          warm_we   = 1'b1;
          warm_wd   = 1'b0;
          rr_we     = 1'b1;
          rr_wd     = 8'd0;
          seen_set  = 1'b1;
          status_d  = ST_REJ_RESTART;
          acc_d     = 1'b1;
        end else begin
          rr_we    = 1'b1;
          rr_wd    = rr_inc;
          status_d = ST_OUTLIER;
          acc_d    = 1'b0;
          sum_clr  = 1'b0;
          state_d  = S_OUT;
        end
      end
      S_DIV: begin
        div_start = 1'b1;
        state_d   = S_DIVW;
      end
      S_DIVW: begin
        if (!div_busy_s && !div_busy_t) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (sum_clr) begin
      k_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= M_FINAL;
      status_q    <= ST_ACCEPT;
      acc_q       <= 1'b0;
      k_q         <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
      warm_q      <= '0;
      seen_q      <= '0;
      for (int i = 0; i < MAX_TARGETS; i++) begin
        fill_q[i] <= '0;
        head_q[i] <= '0;
        rrun_q[i] <= '0;
      end
    end else begin
      state_q  <= state_d;
      mode_q   <= mode_d;
      status_q <= status_d;
      acc_q    <= acc_d;
      k_q      <= k_d;
      v1_q     <= issue;
      v2_q     <= v1_q;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (fill_we) begin
        fill_q[tgt_q] <= fill_wd;
      end
      if (head_we) begin
        head_q[tgt_q] <= head_wd;
      end
      if (rr_we) begin
        rrun_q[tgt_q] <= rr_wd;
      end
      if (warm_we) begin
        warm_q[tgt_q] <= warm_wd;
      end
      if (q_pop_o && q_item_i.frame_start) begin
        seen_q <= '0;
      end else if (seen_set) begin
        seen_q[tgt_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      dist_mem[mem_waddr]  <= item_q.distance;
      stamp_mem[mem_waddr] <= item_q.stamp;
    end
    rd_dist_q  <= dist_mem[mem_raddr];
    rd_stamp_q <= stamp_mem[mem_raddr];
  end

  // item latch, window sums and the statistics pipeline
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      item_q <= q_item_i;
      tgt_q  <= TW'(q_item_i.partner_id);
    end
    sq_q <= (2 * DIST_W)'(rd_dist_q) * (2 * DIST_W)'(rd_dist_q);
    if (sum_clr) begin
      s_q  <= '0;
      q_q  <= '0;
      ts_q <= '0;
    end else begin
      if (v1_q) begin
        s_q  <= s_q + SW'(rd_dist_q);
        ts_q <= ts_q + TSW'(rd_stamp_q);
      end
      if (v2_q) begin
        q_q <= q_q + QW'(sq_q);
      end
    end
    nq_q   <= VW'(fill_cur) * VW'(q_q);
    ss_q   <= VW'(s_q) * VW'(s_q);
    nn_q   <= NNW'(fill_cur) * NNW'(fill_cur);
    w2_q   <= SQ12W'(cfg_i.warmup_sigma_mm) * SQ12W'(cfg_i.warmup_sigma_mm);
    ms2_q  <= SQ12W'(cfg_i.min_sigma_mm) * SQ12W'(cfg_i.min_sigma_mm);
    z2_q   <= 16'(cfg_i.z_limit_q4_4) * 16'(cfg_i.z_limit_q4_4);
    nd_q   <= SW'(fill_cur) * SW'(item_q.distance);
    var_q  <= nq_q - ss_q;
    thr_q  <= THW'(nn_q) * THW'(w2_q);
    flo_q  <= THW'(nn_q) * THW'(ms2_q);
    diff_q <= (nd_q > s_q) ? nd_q - s_q : s_q - nd_q;
    varm_q <= (VW'(flo_q) > var_q) ? VW'(flo_q) : var_q;
    lhs_q  <= (2 * SW)'(diff_q) * (2 * SW)'(diff_q);
    rhs_q  <= RW'(z2_q) * RW'(varm_q);
  end

  ztf_div #(.DW(TSW), .NW(FW)) u_div_dist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .divisor_i  (fill_cur),
    .dividend_i (TSW'(s_q)),
    .busy_o     (div_busy_s),
    .quot_o     (quot_s)
  );

  ztf_div #(.DW(TSW), .NW(FW)) u_div_stamp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .divisor_i  (fill_cur),
    .dividend_i (ts_q),
    .busy_o     (div_busy_t),
    .quot_o     (quot_t)
  );

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_acc_q    <= acc_q;
      out_status_q <= status_q;
      out_target_q <= item_q.partner_id;
      out_mm_q     <= acc_q ? quot_s[DIST_W-1:0] : '0;
      out_stamp_q  <= acc_q ? quot_t[STAMP_W-1:0] : '0;
      out_fill_q   <= acc_q ? FILL_W'(fill_cur) : '0;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign accepted_o           = out_acc_q;
  assign status_o             = out_status_q;
  assign out_target_o         = out_target_q;
  assign filtered_mm_o        = out_mm_q;
  assign effective_stamp_us_o = out_stamp_q;
  assign fill_count_o         = out_fill_q;

endmodule
